### sv/dbqdz_pkg.sv
// Shared types, widths, register indexes and reset values for the dual biquad low-pass block.
package dbqdz_pkg;

    localparam int DBQDZ_CHANNELS = 2;
    localparam int DATA_W         = 32;
    localparam int COEF_W         = 18;
    localparam int DB_W           = 31;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic signed [COEF_W-1:0] FORWARD_GAIN_RST = 18'sd13538;
    localparam logic signed [COEF_W-1:0] FEEDBACK_ONE_RST = 18'sd24217;
    localparam logic signed [COEF_W-1:0] FEEDBACK_TWO_RST = -18'sd12833;
    localparam logic        [DB_W-1:0]   DEAD_BAND_RST    = 31'd49152;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_GAIN = 2'd0,
        CFG_FEEDBACK_ONE = 2'd1,
        CFG_FEEDBACK_TWO = 2'd2,
        CFG_DEAD_BAND    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] forward_gain;
        logic signed [COEF_W-1:0] feedback_one;
        logic signed [COEF_W-1:0] feedback_two;
        logic        [DB_W-1:0]   dead_band;
    } t_coef;

endpackage

### sv/dbqdz_chan.sv
// One filter channel: second-order low-pass recursion, rounding, saturation and dead band.
module dbqdz_chan (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic signed [dbqdz_pkg::DATA_W-1:0]   i_x,
    input  dbqdz_pkg::t_coef                      i_coef,
    output logic signed [dbqdz_pkg::DATA_W-1:0]   o_held_nxt
);
    import dbqdz_pkg::*;

    localparam int SUM_W  = DATA_W + 2;
    localparam int PY_W   = COEF_W + DATA_W;
    localparam int PX_W   = COEF_W + SUM_W;
    localparam int ACC_W  = PX_W + 2;
    localparam int RND_W  = ACC_W - 16;
    localparam int DIFF_W = DATA_W + 1;

    localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    localparam logic signed [RND_W-1:0] SAT_MIN = RND_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);

    logic signed [DATA_W-1:0] r_x1, r_x2, r_y1, r_y2, r_held;
    logic signed [DATA_W-1:0] n_y, n_held;

    logic signed [SUM_W-1:0]  w_sum;
    logic signed [PX_W-1:0]   w_px;
    logic signed [PY_W-1:0]   w_py1, w_py2;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [RND_W-1:0]  w_rnd;
    logic signed [DIFF_W-1:0] w_diff;
    logic        [DIFF_W-1:0] w_abs;

    always_comb begin
        w_sum  = SUM_W'(i_x) + (SUM_W'(r_x1) <<< 1) + SUM_W'(r_x2);
        w_px   = i_coef.forward_gain * w_sum;
        w_py1  = i_coef.feedback_one * r_y1;
        w_py2  = i_coef.feedback_two * r_y2;
        w_acc  = ACC_W'(w_px) + ACC_W'(w_py1) + ACC_W'(w_py2);
        w_rnd  = RND_W'((w_acc + RND_HALF) >>> 16);
        priority if (w_rnd > SAT_MAX) begin
            n_y = SAT_MAX[DATA_W-1:0];
        end else if (w_rnd < SAT_MIN) begin
            n_y = SAT_MIN[DATA_W-1:0];
        end else begin
            n_y = w_rnd[DATA_W-1:0];
        end
        w_diff = DIFF_W'(n_y) - DIFF_W'(r_held);
        w_abs  = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
        n_held = (w_abs > DIFF_W'(i_coef.dead_band)) ? n_y : r_held;
    end

    assign o_held_nxt = n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1   <= '0;
            r_x2   <= '0;
            r_y1   <= '0;
            r_y2   <= '0;
            r_held <= '0;
        end else if (i_en) begin
            r_x1   <= i_x;
            r_x2   <= r_x1;
            r_y1   <= n_y;
            r_y2   <= r_y1;
            r_held <= n_held;
        end
    end

endmodule

### sv/dual_biquad_lowpass_deadzone.sv
// Top level: two-channel biquad low-pass filter with dead band, input and result registers.
// A transfer passes the input register, then the result register (two register stages).
// Throughput: one item per cycle unless stalled; the multiply-add recursion is combinational.
// An item is taken into an empty input register while a finished result waits.
// Reset (synchronous, active low) empties both stages, zeroes filter history and held
// outputs, and loads the default coefficients and dead band.
module dual_biquad_lowpass_deadzone #(
    parameter int CHANNELS = dbqdz_pkg::DBQDZ_CHANNELS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_read_ok,
    input  logic                                    i_is_sample,
    input  logic signed [dbqdz_pkg::DATA_W-1:0]     i_angle_in,
    input  logic signed [dbqdz_pkg::DATA_W-1:0]     i_stretch_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_result_valid,
    output logic signed [dbqdz_pkg::DATA_W-1:0]     o_angle_out,
    output logic signed [dbqdz_pkg::DATA_W-1:0]     o_stretch_out,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [dbqdz_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dbqdz_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import dbqdz_pkg::*;

    t_coef r_coef;

    logic                     r_in_valid;
    logic                     r_in_read_ok;
    logic                     r_in_is_sample;
    logic signed [DATA_W-1:0] r_in_angle;
    logic signed [DATA_W-1:0] r_in_stretch;

    logic                     r_out_valid;
    logic                     r_result_valid;
    logic signed [DATA_W-1:0] r_angle_out;
    logic signed [DATA_W-1:0] r_stretch_out;

    logic                     w_advance;
    logic                     w_filt_en;
    logic signed [DATA_W-1:0] w_held [CHANNELS];
    logic signed [DATA_W-1:0] w_stretch_flt;
    logic                     n_result_valid;
    logic signed [DATA_W-1:0] n_angle_out;
    logic signed [DATA_W-1:0] n_stretch_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.forward_gain <= FORWARD_GAIN_RST;
            r_coef.feedback_one <= FEEDBACK_ONE_RST;
            r_coef.feedback_two <= FEEDBACK_TWO_RST;
            r_coef.dead_band    <= DEAD_BAND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FORWARD_GAIN: r_coef.forward_gain <= i_cfg_data[COEF_W-1:0];
                CFG_FEEDBACK_ONE: r_coef.feedback_one <= i_cfg_data[COEF_W-1:0];
                CFG_FEEDBACK_TWO: r_coef.feedback_two <= i_cfg_data[COEF_W-1:0];
                CFG_DEAD_BAND:    r_coef.dead_band    <= i_cfg_data[DB_W-1:0];
                default:          r_coef              <= r_coef;
            endcase
        end
    end

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_filt_en  = w_advance && r_in_read_ok && r_in_is_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_read_ok   <= i_read_ok;
            r_in_is_sample <= i_is_sample;
            r_in_angle     <= i_angle_in;
            r_in_stretch   <= i_stretch_in;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        logic signed [DATA_W-1:0] w_x;
        if (g == 0) begin : g_angle
            assign w_x = r_in_angle;
        end else if (g == 1) begin : g_stretch
            assign w_x = r_in_stretch;
        end else begin : g_spare
            assign w_x = '0;
        end
        dbqdz_chan u_chan (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_filt_en),
            .i_x        (w_x),
            .i_coef     (r_coef),
            .o_held_nxt (w_held[g])
        );
    end

    if (CHANNELS > 1) begin : g_two
        assign w_stretch_flt = w_held[1];
    end else begin : g_one
        assign w_stretch_flt = '0;
    end

    always_comb begin
        priority if (!r_in_read_ok) begin
            n_result_valid = 1'b0;
            n_angle_out    = '0;
            n_stretch_out  = '0;
        end else if (r_in_is_sample) begin
            n_result_valid = 1'b1;
            n_angle_out    = w_held[0];
            n_stretch_out  = w_stretch_flt;
        end else begin
            n_result_valid = 1'b1;
            n_angle_out    = r_in_angle;
            n_stretch_out  = r_in_stretch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result_valid <= n_result_valid;
            r_angle_out    <= n_angle_out;
            r_stretch_out  <= n_stretch_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_valid = r_result_valid;
    assign o_angle_out    = r_angle_out;
    assign o_stretch_out  = r_stretch_out;

endmodule

### sv/dbqdz_chk.sv
// Port-level checker for the dual biquad low-pass block, with its bind statement.
module dbqdz_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_valid,
    input logic [31:0] o_angle_out,
    input logic [31:0] o_stretch_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_valid)
            && $stable(o_angle_out) && $stable(o_stretch_out))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_valid |-> o_angle_out == 32'd0 && o_stretch_out == 32'd0)
        else $error("failed read carries nonzero data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with result side free");

endmodule

bind dual_biquad_lowpass_deadzone dbqdz_chk u_dbqdz_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_valid (o_result_valid),
    .o_angle_out    (o_angle_out),
    .o_stretch_out  (o_stretch_out)
);
